### rtl/core/smr_pkg.sv
// ----------------------------------------------------------------------------
// smr_pkg
// Shared types and constants for the spiral matrix reorder block.
// ----------------------------------------------------------------------------
package smr_pkg;

	localparam int VAL_W     = 32;
	localparam int CFG_W     = 4;
	localparam int CFG_IDX_W = 1;
	localparam int DIM_W     = 5;
	localparam int TOT_W     = 2 * DIM_W;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'd1;

	localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

	typedef struct packed {
		logic [DIM_W-1:0] rows;
		logic [DIM_W-1:0] cols;
	} dims_t;

endpackage

### rtl/core/smr_ram.sv
// ----------------------------------------------------------------------------
// smr_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module smr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/core/smr_front.sv
// ----------------------------------------------------------------------------
// smr_front
// Load side: writes row-major beats into the element store and queues one
// emit command (matrix size) when the matrix is complete.
// ----------------------------------------------------------------------------
module smr_front #(
	parameter int MAX_ROWS = 8,
	parameter int MAX_COLS = 8,
	localparam int DEPTH = MAX_ROWS * MAX_COLS,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [smr_pkg::VAL_W-1:0] element_value,
	input  smr_pkg::dims_t              dims,
	input  logic                        back_busy,
	output logic                        ram_we,
	output logic [AW-1:0]               ram_waddr,
	output logic [smr_pkg::VAL_W-1:0]   ram_wdata,
	output logic                        cmd_valid,
	input  logic                        cmd_ready,
	output smr_pkg::dims_t              cmd
);

	localparam int LW = $clog2(DEPTH + 1);
	localparam int TW = smr_pkg::TOT_W;

	logic [LW-1:0]  load_q;
	logic [LW-1:0]  load_inc;
	logic [TW-1:0]  total;
	logic           room;
	logic           acc;
	logic           done;
	logic           cmd_valid_q;
	smr_pkg::dims_t cmd_q;

	assign in_ready  = !cmd_valid_q && !back_busy;
	assign acc       = in_valid && in_ready;
	assign total     = TW'(dims.rows) * TW'(dims.cols);
	assign room      = load_q < LW'(DEPTH);
	assign load_inc  = room ? load_q + LW'(1) : load_q;
	assign done      = TW'(load_inc) >= total;

	assign ram_we    = acc && room;
	assign ram_waddr = load_q[AW-1:0];
	assign ram_wdata = element_value;

	assign cmd_valid = cmd_valid_q;
	assign cmd       = cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q      <= '0;
			cmd_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				if (done) begin
					load_q      <= '0;
					cmd_valid_q <= 1'b1;
				end else begin
					load_q <= load_inc;
				end
			end else if (cmd_valid_q && cmd_ready) begin
				cmd_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && done) begin
			cmd_q <= dims;
		end
	end

endmodule

### rtl/core/smr_back.sv
// ----------------------------------------------------------------------------
// smr_back
// Emit side: walks the anticlockwise spiral one cell per cycle while its
// two-entry output queue has room, reads the store and buffers results there.
// ----------------------------------------------------------------------------
module smr_back #(
	parameter int MAX_ROWS = 8,
	parameter int MAX_COLS = 8,
	localparam int DEPTH = MAX_ROWS * MAX_COLS,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	output logic                        cmd_ready,
	input  smr_pkg::dims_t              cmd,
	output logic                        busy,
	output logic                        ram_re,
	output logic [AW-1:0]               ram_raddr,
	input  logic [smr_pkg::VAL_W-1:0]   ram_rdata,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [smr_pkg::VAL_W-1:0] out_value,
	output logic                        last_of_run
);

	localparam int DW = smr_pkg::DIM_W;
	localparam int TW = smr_pkg::TOT_W;

	localparam logic [1:0] DIR_DOWN  = 2'd0;
	localparam logic [1:0] DIR_RIGHT = 2'd1;
	localparam logic [1:0] DIR_UP    = 2'd2;
	localparam logic [1:0] DIR_LEFT  = 2'd3;

	logic          active_q;
	logic [1:0]    dir_q, dir_nx;
	logic [DW-1:0] r_q, c_q, x_q, r_nx, c_nx, x_nx;
	logic [DW-1:0] n_q, m_q, bot, rgt;
	logic [TW-1:0] total_q, cnt_q, addr_full;
	logic          take, issue, is_last, pop;
	logic [2:0]    occ;

	logic                    v_s2;
	logic                    last_s2;
	logic [smr_pkg::VAL_W-1:0] oq_data_q [2];
	logic                    oq_last_q [2];
	logic                    wr_ptr_q, rd_ptr_q;
	logic [1:0]              oq_cnt_q;

	assign cmd_ready = !active_q;
	assign take      = cmd_valid && !active_q;
	assign busy      = active_q;

	assign pop   = out_valid && out_ready;
	assign occ   = 3'(oq_cnt_q) + 3'(v_s2);
	assign issue = active_q && ((occ < 3'd2) || ((occ == 3'd2) && pop));

	assign addr_full = TW'(r_q) * TW'(m_q) + TW'(c_q);
	assign ram_raddr = addr_full[AW-1:0];
	assign ram_re    = issue;
	assign is_last   = (cnt_q + TW'(1)) == total_q;

	assign bot = n_q - DW'(1) - x_q;
	assign rgt = m_q - DW'(1) - x_q;

	always_comb begin
		dir_nx = dir_q;
		r_nx   = r_q;
		c_nx   = c_q;
		x_nx   = x_q;
		case (dir_q)
			DIR_DOWN: begin
				if (r_q < bot) begin
					r_nx = r_q + DW'(1);
				end else begin
					dir_nx = DIR_RIGHT;
					c_nx   = c_q + DW'(1);
				end
			end
			DIR_RIGHT: begin
				if (c_q < rgt) begin
					c_nx = c_q + DW'(1);
				end else begin
					dir_nx = DIR_UP;
					r_nx   = r_q - DW'(1);
				end
			end
			DIR_UP: begin
				if (r_q > x_q) begin
					r_nx = r_q - DW'(1);
				end else begin
					dir_nx = DIR_LEFT;
					c_nx   = c_q - DW'(1);
				end
			end
			DIR_LEFT: begin
				if (c_q > x_q + DW'(1)) begin
					c_nx = c_q - DW'(1);
				end else begin
					// corner of the next ring
					dir_nx = DIR_DOWN;
					r_nx   = r_q + DW'(1);
					x_nx   = x_q + DW'(1);
				end
			end
			default: begin
				dir_nx = DIR_DOWN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			dir_q    <= DIR_DOWN;
			r_q      <= '0;
			c_q      <= '0;
			x_q      <= '0;
			cnt_q    <= '0;
			v_s2     <= 1'b0;
		end else begin
			v_s2 <= issue;
			if (take) begin
				active_q <= 1'b1;
				dir_q    <= DIR_DOWN;
				r_q      <= '0;
				c_q      <= '0;
				x_q      <= '0;
				cnt_q    <= '0;
			end else if (issue) begin
				dir_q <= dir_nx;
				r_q   <= r_nx;
				c_q   <= c_nx;
				x_q   <= x_nx;
				cnt_q <= cnt_q + TW'(1);
				if (is_last) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			n_q     <= cmd.rows;
			m_q     <= cmd.cols;
			total_q <= TW'(cmd.rows) * TW'(cmd.cols);
		end
		if (issue) begin
			last_s2 <= is_last;
		end
		if (v_s2) begin
			oq_data_q[wr_ptr_q] <= ram_rdata;
			oq_last_q[wr_ptr_q] <= last_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			oq_cnt_q <= '0;
		end else begin
			if (v_s2) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			oq_cnt_q <= oq_cnt_q + 2'(v_s2) - 2'(pop);
		end
	end

	assign out_valid   = oq_cnt_q != 2'd0;
	assign out_value   = oq_data_q[rd_ptr_q];
	assign last_of_run = oq_last_q[rd_ptr_q];

endmodule

### rtl/core/spiral_matrix_reorder_top.sv
// ----------------------------------------------------------------------------
// spiral_matrix_reorder_top
// Loads rows x cols beats row-major, emits them in anticlockwise spiral order.
// The first result passes the command register, walker start, store read and
// output queue, then one per cycle follows while out_ready holds; the next
// load waits until the walker issues its last read, and output stalls hold
// the walker. Reset: sizes 8 x 8, load count and queues cleared, store kept.
// ----------------------------------------------------------------------------
module spiral_matrix_reorder_top #(
	parameter int MAX_ROWS = 8,
	parameter int MAX_COLS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [smr_pkg::VAL_W-1:0]    element_value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [smr_pkg::VAL_W-1:0]    out_value,
	output logic                                last_of_run,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [smr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [smr_pkg::CFG_W-1:0]           cfg_data
);

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int DW = smr_pkg::DIM_W;

	logic [smr_pkg::CFG_W-1:0] rows_cfg_q, cols_cfg_q;
	logic [DW-1:0]             rows_ext, cols_ext;
	smr_pkg::dims_t            dims;
	smr_pkg::dims_t            cmd;
	logic                      cmd_valid, cmd_ready, back_busy;
	logic                      ram_we, ram_re;
	logic [AW-1:0]             ram_waddr, ram_raddr;
	logic [smr_pkg::VAL_W-1:0] ram_wdata, ram_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_cfg_q <= smr_pkg::DIM_RESET;
			cols_cfg_q <= smr_pkg::DIM_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				smr_pkg::REG_ROWS: rows_cfg_q <= cfg_data;
				smr_pkg::REG_COLS: cols_cfg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// zero acts as one, oversize clamps to the maximum
	assign rows_ext = DW'(rows_cfg_q);
	assign cols_ext = DW'(cols_cfg_q);

	always_comb begin
		if (rows_ext == '0) begin
			dims.rows = DW'(1);
		end else if (rows_ext > DW'(MAX_ROWS)) begin
			dims.rows = DW'(MAX_ROWS);
		end else begin
			dims.rows = rows_ext;
		end
		if (cols_ext == '0) begin
			dims.cols = DW'(1);
		end else if (cols_ext > DW'(MAX_COLS)) begin
			dims.cols = DW'(MAX_COLS);
		end else begin
			dims.cols = cols_ext;
		end
	end

	smr_front #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.element_value(element_value),
		.dims         (dims),
		.back_busy    (back_busy),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.cmd          (cmd)
	);

	smr_ram #(
		.WIDTH(smr_pkg::VAL_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	smr_back #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd),
		.busy       (back_busy),
		.ram_re     (ram_re),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_value  (out_value),
		.last_of_run(last_of_run)
	);

	// no load beat while an emit command is pending
	a_no_load_with_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> !cmd_valid)
		else $error("load beat accepted with emit command pending");

	// store is never written while the walker still reads it
	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !back_busy)
		else $error("store write during spiral walk");

	a_cmd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_ready) |=> (cmd_valid && $stable(cmd)))
		else $error("emit command dropped or changed while stalled");

	a_walk_from_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(back_busy) |-> $past(cmd_valid))
		else $error("spiral walk started without a command");

endmodule

### tb/spiral_matrix_reorder_checker.sv
// ----------------------------------------------------------------------------
// spiral_matrix_reorder_checker
// Passive monitor for the spiral reorder block. Tracks size register writes
// and accepted element beats, builds the expected anticlockwise spiral when a
// matrix completes, and compares every accepted output beat against it.
// ----------------------------------------------------------------------------
module spiral_matrix_reorder_checker
	import smr_pkg::*;
#(
	parameter int MAX_ROWS = 8,
	parameter int MAX_COLS = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic signed [VAL_W-1:0]   element_value,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  logic signed [VAL_W-1:0]   out_value,
	input  logic                      last_of_run,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_W-1:0]          cfg_data,
	output int                        pending,
	output int                        errors
);

	localparam int DEPTH = MAX_ROWS * MAX_COLS;

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic                    last;
	} spiral_beat_t;

	logic [CFG_W-1:0]        rows_cfg;
	logic [CFG_W-1:0]        cols_cfg;
	logic signed [VAL_W-1:0] elem_store [DEPTH];
	int                      load_cnt;
	int                      walk_rows;
	int                      walk_cols;
	int                      walk_total;
	int                      emitted;
	spiral_beat_t            spiral_q[$];

	function automatic int clamp_dim(input logic [CFG_W-1:0] raw, input int lim);
		if (raw == 0)
			return 1;
		if (int'(raw) > lim)
			return lim;
		return int'(raw);
	endfunction

	// appends one cell of the walk; cells past the matrix total are dropped
	function automatic void emit_cell(input int r, input int c);
		spiral_beat_t b;
		if (emitted >= walk_total)
			return;
		b.value = elem_store[r * walk_cols + c];
		emitted++;
		b.last = (emitted == walk_total);
		spiral_q.push_back(b);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $time, msg);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		spiral_beat_t want;
		if (!arst_n) begin
			rows_cfg = DIM_RESET;
			cols_cfg = DIM_RESET;
			load_cnt = 0;
			spiral_q.delete();
			pending  = 0;
			errors   = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ROWS: rows_cfg = cfg_data;
					REG_COLS: cols_cfg = cfg_data;
					default: ;
				endcase
			end

			if (out_valid && out_ready) begin
				if (spiral_q.size() == 0) begin
					report_mismatch($sformatf("unexpected beat: value %0d last %0b",
						out_value, last_of_run));
				end else begin
					want = spiral_q.pop_front();
					if (out_value !== want.value)
						report_mismatch($sformatf("out_value: got %0d, expected %0d",
							out_value, want.value));
					if (last_of_run !== want.last)
						report_mismatch($sformatf("last_of_run: got %b, expected %b (value %0d)",
							last_of_run, want.last, want.value));
				end
			end

			if (in_valid && in_ready) begin
				if (load_cnt < DEPTH) begin
					elem_store[load_cnt] = element_value;
					load_cnt++;
				end
				walk_rows  = clamp_dim(rows_cfg, MAX_ROWS);
				walk_cols  = clamp_dim(cols_cfg, MAX_COLS);
				walk_total = walk_rows * walk_cols;
				// size in effect now decides; a shrink mid-load completes on the next beat
				if (load_cnt >= walk_total) begin
					emitted = 0;
					for (int x = 0; x < MAX_ROWS + MAX_COLS; x++) begin
						for (int i = x; i < walk_rows - x; i++)
							emit_cell(i, x);
						for (int j = x + 1; j < walk_cols - x; j++)
							emit_cell(walk_rows - 1 - x, j);
						for (int i = walk_rows - 2 - x; i >= x; i--)
							emit_cell(i, walk_cols - 1 - x);
						for (int j = walk_cols - 2 - x; j > x; j--)
							emit_cell(x, j);
					end
					load_cnt = 0;
				end
			end

			pending = spiral_q.size();
		end
	end

endmodule

### tb/tb_spiral_matrix_reorder_top.sv
// ----------------------------------------------------------------------------
// tb_spiral_matrix_reorder_top
// Stimulus and verdict for the spiral reorder block. Covers extreme and
// out-of-range sizes, element extremes and a size shrink in the middle of a
// load, then streams random matrices with random gaps on both channels.
// Prediction and comparison live in spiral_matrix_reorder_checker.
// ----------------------------------------------------------------------------
module tb_spiral_matrix_reorder_top;
	import smr_pkg::*;

	localparam int MAX_R        = 8;
	localparam int MAX_C        = 8;
	localparam int RAND_ITEMS   = 130;
	localparam int QUIET_TAIL   = 30;
	localparam int DRAIN_GAP    = 12;
	localparam int STALL_LIMIT  = 2000;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic signed [VAL_W-1:0]  element_value;
	logic                     out_valid;
	logic                     out_ready;
	logic signed [VAL_W-1:0]  out_value;
	logic                     last_of_run;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [CFG_W-1:0]         cfg_data;

	int                       pending;
	int                       errors;
	int                       sent;
	int                       idle_cycles;
	bit                       quiet_run;
	logic [CFG_W-1:0]         cur_rows;
	logic [CFG_W-1:0]         cur_cols;

	spiral_matrix_reorder_top #(
		.MAX_ROWS(MAX_R),
		.MAX_COLS(MAX_C)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.element_value(element_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_value    (out_value),
		.last_of_run  (last_of_run),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	spiral_matrix_reorder_checker #(
		.MAX_ROWS(MAX_R),
		.MAX_COLS(MAX_C)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.element_value(element_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_value    (out_value),
		.last_of_run  (last_of_run),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pending      (pending),
		.errors       (errors)
	);

	always #5 clk = ~clk;

	function automatic int dim_of(input logic [CFG_W-1:0] raw, input int lim);
		if (raw == 0)
			return 1;
		if (int'(raw) > lim)
			return lim;
		return int'(raw);
	endfunction

	function automatic logic [CFG_W-1:0] pick_dim();
		if ($urandom_range(0, 5) == 0)
			return CFG_W'($urandom_range(0, 15));
		return CFG_W'($urandom_range(1, 4));
	endfunction

	function automatic int matrix_size();
		return dim_of(cur_rows, MAX_R) * dim_of(cur_cols, MAX_C);
	endfunction

	task automatic send_element(input logic signed [VAL_W-1:0] v);
		if (!quiet_run && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		in_valid      <= 1'b1;
		element_value <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	task automatic load_random(input int n);
		logic signed [VAL_W-1:0] v;
		for (int i = 0; i < n && sent < RAND_ITEMS; i++) begin
			if (sent >= RAND_ITEMS - QUIET_TAIL)
				quiet_run = 1'b1;
			v = $urandom;
			case ($urandom_range(0, 15))
				0: v = 32'sh8000_0000;
				1: v = 32'sh7FFF_FFFF;
				2: v = '0;
				3: v = -1;
				default: ;
			endcase
			send_element(v);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_size(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] c);
		write_reg(REG_ROWS, r);
		write_reg(REG_COLS, c);
		cfg_valid <= 1'b0;
		cur_rows = r;
		cur_cols = c;
	endtask

	// hold the sender until every predicted beat is out, then let the block settle
	task automatic wait_drain();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_GAP) @(negedge clk);
	endtask

	// receiver stalls in random bursts, none in the closing stretch
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!quiet_run && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		int total;
		int part;
		int fresh;
		clk           = 1'b0;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		element_value = '0;
		out_ready     = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_ROWS;
		cfg_data      = '0;
		sent          = 0;
		idle_cycles   = 0;
		quiet_run     = 1'b0;
		cur_rows      = DIM_RESET;
		cur_cols      = DIM_RESET;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// single element, then zero sizes that act as one
		set_size(4'd1, 4'd1);
		send_element(32'sh7FFF_FFFF);
		wait_drain();
		set_size(4'd0, 4'd0);
		send_element(32'sh8000_0000);
		wait_drain();

		// oversize rows clamp to the maximum: one column of eight
		set_size(4'd15, 4'd0);
		send_element('0);
		send_element(-1);
		send_element(32'sd1);
		send_element(-32'sd2);
		send_element(32'sh5555_5555);
		send_element(32'shAAAA_AAAA);
		send_element(32'sh7FFF_FFFF);
		send_element(32'sh8000_0000);
		wait_drain();

		// one row of eight via an oversize column count
		set_size(4'd1, 4'd9);
		for (int i = 0; i < 8; i++)
			send_element(32'sd1 <<< (4 * i + 3));
		wait_drain();

		// shrink mid-load: 3 of 6 loaded, then 2x1 makes the next beat complete it
		set_size(4'd3, 4'd2);
		for (int i = 0; i < 3; i++)
			send_element(32'sd100 + i);
		wait_drain();
		set_size(4'd2, 4'd1);
		send_element(-32'sd100);
		wait_drain();

		sent = 0;
		set_size(4'd8, 4'd8);
		while (sent < RAND_ITEMS) begin
			if ($urandom_range(0, 2) == 0) begin
				wait_drain();
				set_size(pick_dim(), pick_dim());
			end
			total = matrix_size();
			if (total > 1 && $urandom_range(0, 7) == 0) begin
				part = $urandom_range(1, total - 1);
				load_random(part);
				wait_drain();
				set_size(pick_dim(), pick_dim());
				fresh = matrix_size();
				total = (fresh > part) ? fresh - part : 1;
			end
			load_random(total);
		end

		wait_drain();
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
